FILE: hdl/byte_ring_fifo_with_spans_assert.svh
// Assertion macros for the byte ring FIFO, clocked on clk, reset by rst_n.
`ifndef BYTE_RING_FIFO_WITH_SPANS_ASSERT_SVH
`define BYTE_RING_FIFO_WITH_SPANS_ASSERT_SVH
`ifndef SYNTH
`define BRF_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define BRF_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define BRF_ASSERT_IMP(lbl, ante, cons)
`define BRF_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

FILE: hdl/brf_pkg.sv
package brf_pkg;

    localparam int DEPTH  = 256;

    localparam int ACT_W  = 3;
    localparam int BYTE_W = 8;
    localparam int AMT_W  = 9;
    localparam int LVL_W  = 9;

    localparam logic [ACT_W-1:0] ACT_PUT     = 3'd0;
    localparam logic [ACT_W-1:0] ACT_GET     = 3'd1;
    localparam logic [ACT_W-1:0] ACT_PEEK    = 3'd2;
    localparam logic [ACT_W-1:0] ACT_DISCARD = 3'd3;
    localparam logic [ACT_W-1:0] ACT_CLEAR   = 3'd4;

    typedef struct packed {
        logic [ACT_W-1:0]  action;
        logic [BYTE_W-1:0] byte_in;
        logic [AMT_W-1:0]  amount;
    } in_item_t;

    typedef struct packed {
        logic              ok;
        logic [BYTE_W-1:0] byte_out;
        logic [LVL_W-1:0]  level;
        logic [LVL_W-1:0]  read_span;
        logic [LVL_W-1:0]  write_span;
    } out_item_t;

    typedef struct packed {
        logic             ok;
        logic             rd_hit;
        logic             we;
        logic [LVL_W-1:0] level;
        logic [LVL_W-1:0] read_span;
        logic [LVL_W-1:0] write_span;
    } res_t;

endpackage

FILE: hdl/brf_chan_if.sv
interface brf_chan_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: hdl/brf_ram.sv
module brf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule

FILE: hdl/brf_ctrl.sv
module brf_ctrl import brf_pkg::*; (
    input  logic [ACT_W-1:0]                 action,
    input  logic [AMT_W-1:0]                 amount,
    input  logic [$clog2(DEPTH)-1:0]         rd_ptr,
    input  logic [$clog2(DEPTH)-1:0]         wr_ptr,
    input  logic [$clog2(DEPTH+1)-1:0]       fill,
    output logic [$clog2(DEPTH)-1:0]         rd_ptr_next,
    output logic [$clog2(DEPTH)-1:0]         wr_ptr_next,
    output logic [$clog2(DEPTH+1)-1:0]       fill_next,
    output res_t                             res
);
    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = ((CW > AMT_W) ? CW : AMT_W) + 1;

    logic          full;
    logic          empty;
    logic [PW-1:0] rd_inc;
    logic [PW-1:0] wr_inc;
    logic [SW-1:0] sum;
    logic [SW-1:0] adv;
    logic          amt_ok;
    logic [CW-1:0] rem_r;
    logic [CW-1:0] rem_w;
    logic [CW-1:0] free;
    logic [CW-1:0] rspan;
    logic [CW-1:0] wspan;
    logic          res_ok;
    logic          res_rd_hit;
    logic          res_we;

    assign full   = (fill == CW'(DEPTH));
    assign empty  = (fill == '0);
    assign rd_inc = (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
    assign wr_inc = (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
    assign sum    = SW'(rd_ptr) + SW'(amount);
    assign adv    = (sum >= SW'(DEPTH)) ? sum - SW'(DEPTH) : sum;
    assign amt_ok = (SW'(amount) <= SW'(fill));

    always_comb
    begin
        rd_ptr_next = rd_ptr;
        wr_ptr_next = wr_ptr;
        fill_next   = fill;
        res_ok      = 1'b0;
        res_rd_hit  = 1'b0;
        res_we      = 1'b0;
        unique case (action)
            ACT_PUT:
            begin
                if (!full)
                begin
                    wr_ptr_next = wr_inc;
                    fill_next   = fill + CW'(1);
                    res_ok      = 1'b1;
                    res_we      = 1'b1;
                end
            end
            ACT_GET:
            begin
                if (!empty)
                begin
                    rd_ptr_next = rd_inc;
                    fill_next   = fill - CW'(1);
                    res_ok      = 1'b1;
                    res_rd_hit  = 1'b1;
                end
            end
            ACT_PEEK:
            begin
                if (!empty)
                begin
                    res_ok     = 1'b1;
                    res_rd_hit = 1'b1;
                end
            end
            ACT_DISCARD:
            begin
                if (amt_ok)
                begin
                    rd_ptr_next = adv[PW-1:0];
                    fill_next   = fill - CW'(amount);
                    res_ok      = 1'b1;
                end
            end
            ACT_CLEAR:
            begin
                rd_ptr_next = '0;
                wr_ptr_next = '0;
                fill_next   = '0;
                res_ok      = 1'b1;
            end
            default:
            begin
                res_ok = 1'b0;
            end
        endcase
    end

    assign rem_r = CW'(DEPTH) - CW'(rd_ptr_next);
    assign rem_w = CW'(DEPTH) - CW'(wr_ptr_next);
    assign free  = CW'(DEPTH) - fill_next;
    assign rspan = (fill_next < rem_r) ? fill_next : rem_r;
    assign wspan = (free < rem_w) ? free : rem_w;

    assign res = '{ok:         res_ok,
                   rd_hit:     res_rd_hit,
                   we:         res_we,
                   level:      LVL_W'(fill_next),
                   read_span:  LVL_W'(rspan),
                   write_span: LVL_W'(wspan)};
endmodule

FILE: hdl/byte_ring_fifo_with_spans.sv
// The result of an item is registered and is valid in the cycle after the item is accepted.
// Throughput: one item per cycle unless rsp stalls; each reads the store, a PUT also writes.
// The byte read comes from the registered read port of the store and is held while stalled.
// Reset (rst_n low, asynchronous) clears the pointers, the fill count and the result valid.
// The byte store is not cleared; no clearing pass follows reset.
`include "byte_ring_fifo_with_spans_assert.svh"
module byte_ring_fifo_with_spans import brf_pkg::*; (
    input logic       clk,
    input logic       rst_n,
    brf_chan_if.sink   req,
    brf_chan_if.source rsp
);
    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = CW + 1;

    logic              acc;
    logic [PW-1:0]     rd_ptr_reg;
    logic [PW-1:0]     rd_ptr_next;
    logic [PW-1:0]     wr_ptr_reg;
    logic [PW-1:0]     wr_ptr_next;
    logic [CW-1:0]     fill_reg;
    logic [CW-1:0]     fill_next;
    logic              rsp_valid_reg;
    res_t              res_next;
    res_t              res_reg;
    logic [BYTE_W-1:0] rdata;
    out_item_t         out_item;
    logic [SW-1:0]     chk_sum;
    logic [SW-1:0]     chk_pos;
    logic              clr_acc;

    assign req.ready = !rsp_valid_reg || rsp.ready;
    assign acc       = req.valid && req.ready;

    brf_ctrl u_ctrl (
        .action      (req.data.action),
        .amount      (req.data.amount),
        .rd_ptr      (rd_ptr_reg),
        .wr_ptr      (wr_ptr_reg),
        .fill        (fill_reg),
        .rd_ptr_next (rd_ptr_next),
        .wr_ptr_next (wr_ptr_next),
        .fill_next   (fill_next),
        .res         (res_next)
    );

    brf_ram #(.WIDTH(BYTE_W), .DEPTH(DEPTH)) u_ram (
        .clk   (clk),
        .we    (acc && res_next.we),
        .waddr (wr_ptr_reg),
        .wdata (req.data.byte_in),
        .re    (acc),
        .raddr (rd_ptr_reg),
        .rdata (rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg    <= '0;
            wr_ptr_reg    <= '0;
            fill_reg      <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (acc)
            begin
                rd_ptr_reg    <= rd_ptr_next;
                wr_ptr_reg    <= wr_ptr_next;
                fill_reg      <= fill_next;
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            res_reg <= res_next;
        end
    end

    assign out_item.ok         = res_reg.ok;
    assign out_item.byte_out   = res_reg.rd_hit ? rdata : '0;
    assign out_item.level      = res_reg.level;
    assign out_item.read_span  = res_reg.read_span;
    assign out_item.write_span = res_reg.write_span;

    assign rsp.valid = rsp_valid_reg;
    assign rsp.data  = out_item;

    assign chk_sum = SW'(rd_ptr_reg) + SW'(fill_reg);
    assign chk_pos = (chk_sum >= SW'(DEPTH)) ? chk_sum - SW'(DEPTH) : chk_sum;
    assign clr_acc = acc && (req.data.action == ACT_CLEAR);

    `BRF_ASSERT_IMP(a_fill_bound, 1'b1, fill_reg <= CW'(DEPTH))
    `BRF_ASSERT_IMP(a_ptr_track, 1'b1, chk_pos[PW-1:0] == wr_ptr_reg)
    `BRF_ASSERT_NXT(a_clear, clr_acc, {fill_reg, rd_ptr_reg, wr_ptr_reg} == '0)
    `BRF_ASSERT_IMP(a_fail_zero, rsp_valid_reg && !res_reg.ok, out_item.byte_out == '0)
endmodule

FILE: test/testbench.sv
module testbench;
    import brf_pkg::*;

    localparam int RING_SIZE = 256;
    localparam int LONG_HOLD = 800;
    localparam int STALL_LIMIT = 4000;
    localparam logic [ACT_W-1:0] ACT_BAD_FIRST = ACT_CLEAR + 3'd1;

    logic clk;
    logic rst_n;

    brf_chan_if #(.T(in_item_t))  req_if ();
    brf_chan_if #(.T(out_item_t)) rsp_if ();

    byte_ring_fifo_with_spans i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if)
    );

    logic [BYTE_W-1:0] ring_bytes [RING_SIZE];
    int unsigned head_ptr;
    int unsigned tail_ptr;
    int unsigned held;

    in_item_t  pending_reqs [$];
    out_item_t expected_results [$];

    int tx_idle_pct;
    int rx_idle_pct;
    int stall_wanted;
    int stall_taken;
    int hold_left;
    int errors;
    int quiet_cycles;
    logic req_fire;

    function automatic int unsigned min_of(int unsigned a, int unsigned b);
        return (a < b) ? a : b;
    endfunction

    function automatic out_item_t fifo_apply(in_item_t item);
        out_item_t res;
        res = '0;
        case (item.action)
            ACT_PUT:
                if (held < RING_SIZE) begin
                    ring_bytes[8'(tail_ptr)] = item.byte_in;
                    tail_ptr = (tail_ptr + 1) % RING_SIZE;
                    held++;
                    res.ok = 1'b1;
                end
            ACT_GET:
                if (held > 0) begin
                    res.byte_out = ring_bytes[8'(head_ptr)];
                    head_ptr = (head_ptr + 1) % RING_SIZE;
                    held--;
                    res.ok = 1'b1;
                end
            ACT_PEEK:
                if (held > 0) begin
                    res.byte_out = ring_bytes[8'(head_ptr)];
                    res.ok = 1'b1;
                end
            ACT_DISCARD:
                if (item.amount <= held) begin
                    head_ptr = (head_ptr + item.amount) % RING_SIZE;
                    held -= item.amount;
                    res.ok = 1'b1;
                end
            ACT_CLEAR:
                begin
                    head_ptr = 0;
                    tail_ptr = 0;
                    held = 0;
                    res.ok = 1'b1;
                end
            default:
                res.ok = 1'b0;
        endcase
        res.level = LVL_W'(held);
        res.read_span = LVL_W'(min_of(held, RING_SIZE - head_ptr));
        res.write_span = LVL_W'(min_of(RING_SIZE - held, RING_SIZE - tail_ptr));
        return res;
    endfunction

    task automatic queue_op(logic [ACT_W-1:0] act, logic [BYTE_W-1:0] b,
                            logic [AMT_W-1:0] amt);
        in_item_t item;
        item.action = act;
        item.byte_in = b;
        item.amount = amt;
        pending_reqs.push_back(item);
    endtask

    function automatic logic [AMT_W-1:0] pick_amount();
        int r;
        r = $urandom_range(99);
        if (r < 70)
            return AMT_W'($urandom_range(0, 6));
        else if (r < 95)
            return AMT_W'($urandom_range(0, RING_SIZE));
        return AMT_W'(RING_SIZE);
    endfunction

    function automatic logic [ACT_W-1:0] pick_action();
        int r;
        r = $urandom_range(99);
        if (r < 38)
            return ACT_PUT;
        else if (r < 62)
            return ACT_GET;
        else if (r < 74)
            return ACT_PEEK;
        else if (r < 93)
            return ACT_DISCARD;
        else if (r < 96)
            return ACT_CLEAR;
        return ACT_BAD_FIRST + ACT_W'($urandom_range(0, 2));
    endfunction

    task automatic run_random(int n);
        int done;
        int len;
        int kind;
        done = 0;
        while (done < n) begin
            kind = $urandom_range(0, 3);
            len = $urandom_range(1, 40);
            for (int k = 0; k < len; k++) begin
                case (kind)
                    0: queue_op(ACT_PUT, BYTE_W'($urandom_range(0, 255)), pick_amount());
                    1: queue_op(($urandom_range(3) == 0) ? ACT_PEEK : ACT_GET,
                                BYTE_W'($urandom_range(0, 255)), pick_amount());
                    default: queue_op(pick_action(), BYTE_W'($urandom_range(0, 255)),
                                      pick_amount());
                endcase
            end
            done += len;
        end
    endtask

    task automatic wait_drained();
        while (pending_reqs.size() != 0 || req_if.valid || expected_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        req_fire <= rst_n && req_if.valid && req_if.ready;
        if (rst_n && req_if.valid && req_if.ready)
            expected_results.push_back(fifo_apply(req_if.data));
    end

    always @(negedge clk)
    begin
        if (rst_n && (!req_if.valid || req_fire)) begin
            if (pending_reqs.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
                req_if.data <= pending_reqs.pop_front();
                req_if.valid <= 1'b1;
            end
            else
                req_if.valid <= 1'b0;
        end
    end

    always @(negedge clk)
    begin
        if (rst_n) begin
            if (stall_wanted != stall_taken) begin
                stall_taken <= stall_wanted;
                hold_left <= LONG_HOLD;
                rsp_if.ready <= 1'b0;
            end
            else if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                rsp_if.ready <= 1'b0;
            end
            else
                rsp_if.ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n && rsp_if.valid && rsp_if.ready) begin
            if (expected_results.size() == 0) begin
                errors++;
                $display("%0t: unexpected result ok=%0d byte=%0h level=%0d rspan=%0d wspan=%0d",
                         $time, rsp_if.data.ok, rsp_if.data.byte_out, rsp_if.data.level,
                         rsp_if.data.read_span, rsp_if.data.write_span);
            end
            else begin
                want = expected_results.pop_front();
                if (rsp_if.data !== want) begin
                    errors++;
                    $display("%0t: expected ok=%0d byte=%0h level=%0d rspan=%0d wspan=%0d",
                             $time, want.ok, want.byte_out, want.level,
                             want.read_span, want.write_span);
                    $display("%0t:   actual ok=%0d byte=%0h level=%0d rspan=%0d wspan=%0d",
                             $time, rsp_if.data.ok, rsp_if.data.byte_out, rsp_if.data.level,
                             rsp_if.data.read_span, rsp_if.data.write_span);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)
            || (pending_reqs.size() == 0 && expected_results.size() == 0))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("[byte_ring_fifo_with_spans] ERROR");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        req_if.valid = 1'b0;
        req_if.data = '0;
        rsp_if.ready = 1'b0;
        tx_idle_pct = 33;
        rx_idle_pct = 62;
        stall_wanted = 0;
        stall_taken = 0;
        hold_left = 0;
        errors = 0;
        quiet_cycles = 0;
        req_fire = 1'b0;
        head_ptr = 0;
        tail_ptr = 0;
        held = 0;
        ring_bytes = '{default: '0};

        // edge cases: empty reads, over-discard, zero discard, unknown codes
        queue_op(ACT_GET, 8'h00, 9'd0);
        queue_op(ACT_PEEK, 8'hFF, 9'd256);
        queue_op(ACT_DISCARD, 8'h00, 9'd1);
        queue_op(ACT_DISCARD, 8'h00, 9'd0);
        queue_op(ACT_PUT, 8'h00, 9'd0);
        queue_op(ACT_PUT, 8'hFF, 9'd256);
        queue_op(ACT_PUT, 8'hA5, 9'd0);
        queue_op(ACT_PEEK, 8'h00, 9'd0);
        queue_op(ACT_GET, 8'h00, 9'd0);
        queue_op(ACT_DISCARD, 8'h00, 9'd256);
        queue_op(ACT_DISCARD, 8'h00, 9'd1);
        queue_op(ACT_GET, 8'h00, 9'd0);
        queue_op(ACT_GET, 8'h00, 9'd0);
        queue_op(ACT_BAD_FIRST, 8'hFF, 9'd256);
        queue_op(ACT_BAD_FIRST + 3'd1, 8'h5A, 9'd3);
        queue_op(ACT_BAD_FIRST + 3'd2, 8'hFF, 9'd0);
        queue_op(ACT_PUT, 8'h3C, 9'd0);
        queue_op(ACT_PUT, 8'hC3, 9'd0);
        queue_op(ACT_CLEAR, 8'hFF, 9'd256);
        queue_op(ACT_PEEK, 8'h00, 9'd0);
        queue_op(ACT_PUT, 8'h81, 9'd0);
        queue_op(ACT_DISCARD, 8'h00, 9'd1);

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        run_random(300);
        wait_drained();

        tx_idle_pct = 62;
        rx_idle_pct = 33;
        queue_op(ACT_CLEAR, 8'h00, 9'd0);
        for (int k = 0; k < RING_SIZE + 4; k++)
            queue_op(ACT_PUT, BYTE_W'($urandom_range(0, 255)), 9'd0);
        queue_op(ACT_PEEK, 8'h00, 9'd0);
        queue_op(ACT_DISCARD, 8'h00, 9'd256);
        queue_op(ACT_GET, 8'h00, 9'd0);
        // hold the receiver while the fill burst backs up the block
        stall_wanted = stall_wanted + 1;
        run_random(200);
        wait_drained();

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        run_random(300);
        wait_drained();

        if (errors == 0 && expected_results.size() == 0)
            $display("[byte_ring_fifo_with_spans] OK");
        else
            $display("[byte_ring_fifo_with_spans] ERROR");
        $finish;
    end
endmodule
